FILE: rtl/stereo_widener_mono_bass_macros.svh
// Assertion macros for the stereo widener checker.
// Used only by the checker file; depends on signals named clk and rst_n.
`ifndef STEREO_WIDENER_MONO_BASS_MACROS_SVH
`define STEREO_WIDENER_MONO_BASS_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define SWMB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SWMB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/swmb_pkg.sv
// Shared types and constants for the stereo widener with mono bass.
// No dependencies; used by every module of the block.
package swmb_pkg;

    localparam int SAMPLE_BITS         = 24;
    localparam int COEFF_FRAC_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;
    localparam int WIDTH_BITS     = 15;
    localparam int CUTOFF_BITS    = 15;
    localparam int RATE_BITS      = 18;
    localparam int SMOOTH_BITS    = 16;

    localparam int SMOOTH_FRAC = 16;
    localparam int LOW_EXTRA   = 8;
    localparam int SIDE_SHIFT  = 13;
    localparam int CORR_FRAC   = 15;
    localparam int CORR_BITS   = 16;

    localparam logic [19:0] TWO_PI_Q16 = 20'd411775;
    // sqrt(1e-9) expressed in the units of the power accumulators.
    localparam logic [31:0] DEN_MIN    = 32'd2225254900;

    localparam logic [WIDTH_BITS-1:0]  TARGET_WIDTH_RESET  = 15'd4096;
    localparam logic [CUTOFF_BITS-1:0] TARGET_CUTOFF_RESET = 15'd120;
    localparam logic [RATE_BITS-1:0]   SAMPLE_RATE_RESET   = 18'd48000;
    localparam logic [SMOOTH_BITS-1:0] SMOOTH_RESET        = 16'd136;

    localparam int          ITER_BITS  = 64;
    localparam int          STEP_BITS  = 6;
    localparam int          SQRT_STEPS = 32;
    localparam logic [63:0] SQRT_BIT0  = 64'h4000_0000_0000_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TARGET_WIDTH  = 3'd0,
        REG_TARGET_CUTOFF = 3'd1,
        REG_MONO_LOW      = 3'd2,
        REG_SAMPLE_RATE   = 3'd3,
        REG_SMOOTH        = 3'd4,
        REG_MONO_SOURCE   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } iter_op_t;

    typedef struct packed {
        logic                 start;
        iter_op_t             op;
        logic [STEP_BITS-1:0] steps;
    } iter_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_left;
        logic signed [SAMPLE_BITS-1:0] in_right;
        logic                          block_end;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic signed [CORR_BITS-1:0]   correlation;
    } result_t;

endpackage

FILE: rtl/swmb_iter.sv
// Bit-serial divide and square root unit sharing one trial subtractor.
// Depends on swmb_pkg; one quotient or root bit per cycle.
module swmb_iter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swmb_pkg::iter_ctl_t                ctl,
    input  logic [swmb_pkg::ITER_BITS-1:0]     opa,
    input  logic [swmb_pkg::ITER_BITS-1:0]     opb,
    output logic                               done,
    output logic [swmb_pkg::ITER_BITS-1:0]     result
);
    import swmb_pkg::*;

    typedef enum logic {
        U_IDLE,
        U_RUN
    } ustate_t;

    ustate_t              state_reg, state_next;
    iter_op_t             op_reg, op_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 first_reg, first_next;
    logic                 done_reg, done_next;
    logic [ITER_BITS-1:0] x_reg, x_next;
    logic [ITER_BITS-1:0] y_reg, y_next;
    logic [ITER_BITS-1:0] acc_reg, acc_next;

    logic [ITER_BITS-1:0] cmp_a, cmp_b;
    logic [ITER_BITS:0]   diff;
    logic                 ge;

    // Division shifts the remainder before each compare except the first;
    // the square root compares against root plus the current bit weight.
    always_comb
    begin
        cmp_a = (op_reg == OP_SQRT || first_reg) ? x_reg : {x_reg[ITER_BITS-2:0], 1'b0};
        cmp_b = (op_reg == OP_SQRT) ? acc_reg + y_reg : y_reg;
        diff  = {1'b0, cmp_a} - {1'b0, cmp_b};
        ge    = ~diff[ITER_BITS];
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = U_RUN;
                    op_next    = ctl.op;
                    cnt_next   = ctl.steps - STEP_BITS'(1);
                    first_next = 1'b1;
                    x_next     = opa;
                    y_next     = (ctl.op == OP_SQRT) ? SQRT_BIT0 : opb;
                    acc_next   = '0;
                end
            end
            U_RUN:
            begin
                first_next = 1'b0;
                if (op_reg == OP_SQRT)
                begin
                    x_next   = ge ? diff[ITER_BITS-1:0] : x_reg;
                    acc_next = ge ? (acc_reg >> 1) + y_reg : acc_reg >> 1;
                    y_next   = y_reg >> 2;
                end
                else
                begin
                    x_next   = ge ? diff[ITER_BITS-1:0] : cmp_a;
                    acc_next = {acc_reg[ITER_BITS-2:0], ge};
                end
                cnt_next = cnt_reg - STEP_BITS'(1);
                if (cnt_reg == '0)
                begin
                    state_next = U_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            op_reg    <= OP_DIV;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            done_reg  <= done_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

FILE: rtl/stereo_widener_mono_bass.sv
// Stereo widener with mono bass: one sample pair in, one sample pair and the held
// correlation out. Most of an item's time is spent in the bit-serial divide that
// forms the lowpass coefficient; an item with block_end set also runs two 32-step
// square roots and a 16-step divide. All products go through one shared multiplier,
// one per cycle.
module stereo_widener_mono_bass #(
    parameter int COEFF_FRAC_BITS = swmb_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  swmb_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output swmb_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swmb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [swmb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import swmb_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int C    = COEFF_FRAC_BITS;
    localparam int XW   = S + LOW_EXTRA + 1;
    localparam int DW   = XW + 1;
    localparam int HW   = DW + 1;
    localparam int MA   = (HW > 33) ? HW : 33;
    localparam int MB   = (C + 2 > S) ? C + 2 : S;
    localparam int PW   = MA + MB;
    localparam int PWR  = 2 * S;
    localparam int QW   = 49;
    localparam int AREG = 35;
    localparam int DENW = 36;
    localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (LOW_EXTRA - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_MW, ST_MC, ST_WC, ST_MA, ST_DEN, ST_AGO, ST_AWAIT,
        ST_LPL, ST_LPR, ST_LPW, ST_SIDE, ST_OUT, ST_PC, ST_PL, ST_PR, ST_PD,
        ST_SLGO, ST_SLW, ST_SRGO, ST_SRW, ST_MH, ST_ML, ST_MD, ST_CGO, ST_CW,
        ST_FIN
    } state_t;

    // Configuration registers.
    logic [WIDTH_BITS-1:0]  tw_reg;
    logic [CUTOFF_BITS-1:0] tc_reg;
    logic                   mono_low_reg;
    logic [RATE_BITS-1:0]   fs_reg;
    logic [SMOOTH_BITS-1:0] coef_reg;
    logic                   mono_src_reg;

    state_t                  state_reg, state_next;
    logic signed [XW-1:0]    x_l_reg, x_l_next, x_r_reg, x_r_next;
    logic                    be_reg, be_next;
    logic [31:0]             ww_reg, ww_next, wc_reg, wc_next;
    logic [AREG-1:0]         a_reg, a_next;
    logic [C-1:0]            alpha_reg, alpha_next;
    logic signed [XW-1:0]    low_l_reg, low_l_next, low_r_reg, low_r_next;
    logic signed [S-1:0]     out_l_reg, out_l_next, out_r_reg, out_r_next;
    logic signed [PWR-1:0]   cross_reg, cross_next, lpow_reg, lpow_next;
    logic signed [PWR-1:0]   rpow_reg, rpow_next;
    logic [31:0]             sl_reg, sl_next, sr_reg, sr_next;
    logic [QW-1:0]           dacc_reg, dacc_next, d_reg, d_next;
    logic signed [CORR_BITS-1:0] corr_reg, corr_next;
    logic signed [PW-1:0]    p_reg, p_next;
    result_t                 res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [32:0]      dw, dc, smooth_inc;
    logic [DENW-1:0]         den;
    logic signed [DW-1:0]    d_l, d_r;
    logic signed [HW-1:0]    hdiff, mid, lo_mono, lo_l, lo_r;
    logic signed [PW-1:0]    side, sum_l, sum_r;
    logic [PWR-1:0]          pos_l, pos_r, ncross;
    logic [QW-1:0]           dsum;
    logic [C:0]              q_alpha;
    logic [CORR_FRAC:0]      q_corr;
    iter_ctl_t               iter_ctl;
    logic [ITER_BITS-1:0]    iter_opa, iter_opb, iter_result;
    logic                    iter_done;

    function automatic logic signed [S-1:0] out_sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v >>> LOW_EXTRA;
        if (&t[PW-1:S-1] || ~|t[PW-1:S-1])
            return t[S-1:0];
        return t[PW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    endfunction

    // Smoothed power update with factor 66/65536, formed as 64 + 2.
    function automatic logic signed [PWR-1:0] pw_upd(
        input logic signed [PWR-1:0] pw,
        input logic signed [PW-1:0]  prod
    );
        logic signed [PWR:0]   d;
        logic signed [PWR+7:0] t;
        d = (PWR+1)'(prod) - (PWR+1)'(pw);
        t = ((PWR+8)'(d) <<< 6) + ((PWR+8)'(d) <<< 1);
        return PWR'((PWR+8)'(pw) + (t >>> 16));
    endfunction

    swmb_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (iter_ctl),
        .opa    (iter_opa),
        .opb    (iter_opb),
        .done   (iter_done),
        .result (iter_result)
    );

    // Datapath terms shared by several states.
    always_comb
    begin
        dw         = $signed({2'b00, tw_reg, 16'h0}) - $signed({1'b0, ww_reg});
        dc         = $signed({2'b00, tc_reg, 16'h0}) - $signed({1'b0, wc_reg});
        smooth_inc = 33'(p_reg >>> SMOOTH_FRAC);
        den        = {1'b0, a_reg} + {2'b00, fs_reg, 16'h0};
        d_l        = DW'(x_l_reg) - DW'(low_l_reg);
        d_r        = DW'(x_r_reg) - DW'(low_r_reg);
        hdiff      = HW'(d_l) - HW'(d_r);
        mid        = (HW'(d_l) + HW'(d_r)) >>> 1;
        lo_mono    = (HW'(low_l_reg) + HW'(low_r_reg)) >>> 1;
        lo_l       = mono_low_reg ? lo_mono : HW'(low_l_reg);
        lo_r       = mono_low_reg ? lo_mono : HW'(low_r_reg);
        side       = p_reg >>> SIDE_SHIFT;
        sum_l      = PW'(lo_l) + PW'(mid) + side + ROUND;
        sum_r      = PW'(lo_r) + PW'(mid) - side + ROUND;
        pos_l      = lpow_reg[PWR-1] ? '0 : lpow_reg;
        pos_r      = rpow_reg[PWR-1] ? '0 : rpow_reg;
        ncross     = cross_reg[PWR-1] ? PWR'(-cross_reg) : cross_reg;
        dsum       = dacc_reg + QW'(p_reg >>> 16);
        q_alpha    = iter_result[C:0];
        q_corr     = iter_result[CORR_FRAC:0];
    end

    // Shared multiplier operands and the iterative unit's request.
    always_comb
    begin
        mul_a          = '0;
        mul_b          = '0;
        iter_ctl.start = 1'b0;
        iter_ctl.op    = OP_DIV;
        iter_ctl.steps = STEP_BITS'(C + 1);
        iter_opa       = ITER_BITS'(a_reg);
        iter_opb       = ITER_BITS'(den);
        unique case (state_reg)
            ST_MW:
            begin
                mul_a = MA'(dw);
                mul_b = MB'($signed({1'b0, coef_reg}));
            end
            ST_MC:
            begin
                mul_a = MA'(dc);
                mul_b = MB'($signed({1'b0, coef_reg}));
            end
            ST_MA:
            begin
                mul_a = MA'($signed({1'b0, wc_reg}));
                mul_b = MB'($signed({1'b0, TWO_PI_Q16}));
            end
            ST_AGO:
            begin
                iter_ctl.start = 1'b1;
            end
            ST_LPL:
            begin
                mul_a = MA'(d_l);
                mul_b = MB'($signed({1'b0, alpha_reg}));
            end
            ST_LPR:
            begin
                mul_a = MA'(d_r);
                mul_b = MB'($signed({1'b0, alpha_reg}));
            end
            ST_SIDE:
            begin
                mul_a = MA'(hdiff);
                mul_b = MB'($signed({1'b0, ww_reg[30:16]}));
            end
            ST_PC:
            begin
                mul_a = MA'(out_l_reg);
                mul_b = MB'(out_r_reg);
            end
            ST_PL:
            begin
                mul_a = MA'(out_l_reg);
                mul_b = MB'(out_l_reg);
            end
            ST_PR:
            begin
                mul_a = MA'(out_r_reg);
                mul_b = MB'(out_r_reg);
            end
            ST_SLGO:
            begin
                iter_ctl.start = 1'b1;
                iter_ctl.op    = OP_SQRT;
                iter_ctl.steps = STEP_BITS'(SQRT_STEPS);
                iter_opa       = ITER_BITS'({pos_l[PWR-2:0], 16'h0});
            end
            ST_SRGO:
            begin
                iter_ctl.start = 1'b1;
                iter_ctl.op    = OP_SQRT;
                iter_ctl.steps = STEP_BITS'(SQRT_STEPS);
                iter_opa       = ITER_BITS'({pos_r[PWR-2:0], 16'h0});
            end
            ST_MH:
            begin
                mul_a = MA'($signed({1'b0, sl_reg}));
                mul_b = MB'($signed({1'b0, sr_reg[31:16]}));
            end
            ST_ML:
            begin
                mul_a = MA'($signed({1'b0, sl_reg}));
                mul_b = MB'($signed({1'b0, sr_reg[15:0]}));
            end
            ST_CGO:
            begin
                // Only whether the quotient reaches unity and its 15 fraction bits matter.
                iter_ctl.start = 1'b1;
                iter_ctl.steps = STEP_BITS'(CORR_FRAC + 1);
                iter_opa       = ITER_BITS'(ncross);
                iter_opb       = ITER_BITS'(d_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        p_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next     = state_reg;
        x_l_next       = x_l_reg;
        x_r_next       = x_r_reg;
        be_next        = be_reg;
        ww_next        = ww_reg;
        wc_next        = wc_reg;
        a_next         = a_reg;
        alpha_next     = alpha_reg;
        low_l_next     = low_l_reg;
        low_r_next     = low_r_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        cross_next     = cross_reg;
        lpow_next      = lpow_reg;
        rpow_next      = rpow_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        dacc_next      = dacc_reg;
        d_next         = d_reg;
        corr_next      = corr_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    x_l_next   = XW'(sample.in_left) <<< LOW_EXTRA;
                    x_r_next   = mono_src_reg ? XW'(sample.in_left) <<< LOW_EXTRA
                                              : XW'(sample.in_right) <<< LOW_EXTRA;
                    be_next    = sample.block_end;
                    state_next = ST_MW;
                end
            end
            ST_MW:
            begin
                state_next = ST_MC;
            end
            ST_MC:
            begin
                ww_next    = 32'($signed({1'b0, ww_reg}) + smooth_inc);
                state_next = ST_WC;
            end
            ST_WC:
            begin
                wc_next    = 32'($signed({1'b0, wc_reg}) + smooth_inc);
                state_next = ST_MA;
            end
            ST_MA:
            begin
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                a_next     = p_reg[SMOOTH_FRAC+AREG-1:SMOOTH_FRAC];
                state_next = ST_AGO;
            end
            ST_AGO:
            begin
                state_next = ST_AWAIT;
            end
            ST_AWAIT:
            begin
                if (iter_done)
                begin
                    if (den == '0 || q_alpha == '0)
                        alpha_next = C'(1);
                    else if (q_alpha[C])
                        alpha_next = '1;
                    else
                        alpha_next = q_alpha[C-1:0];
                    state_next = ST_LPL;
                end
            end
            ST_LPL:
            begin
                state_next = ST_LPR;
            end
            ST_LPR:
            begin
                low_l_next = XW'(low_l_reg + XW'(p_reg >>> C));
                state_next = ST_LPW;
            end
            ST_LPW:
            begin
                low_r_next = XW'(low_r_reg + XW'(p_reg >>> C));
                state_next = ST_SIDE;
            end
            ST_SIDE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_l_next = out_sat(sum_l);
                out_r_next = out_sat(sum_r);
                state_next = ST_PC;
            end
            ST_PC:
            begin
                state_next = ST_PL;
            end
            ST_PL:
            begin
                cross_next = pw_upd(cross_reg, p_reg);
                state_next = ST_PR;
            end
            ST_PR:
            begin
                lpow_next  = pw_upd(lpow_reg, p_reg);
                state_next = ST_PD;
            end
            ST_PD:
            begin
                rpow_next  = pw_upd(rpow_reg, p_reg);
                state_next = be_reg ? ST_SLGO : ST_FIN;
            end
            ST_SLGO:
            begin
                state_next = ST_SLW;
            end
            ST_SLW:
            begin
                if (iter_done)
                begin
                    sl_next    = iter_result[31:0];
                    state_next = ST_SRGO;
                end
            end
            ST_SRGO:
            begin
                state_next = ST_SRW;
            end
            ST_SRW:
            begin
                if (iter_done)
                begin
                    sr_next    = iter_result[31:0];
                    state_next = ST_MH;
                end
            end
            ST_MH:
            begin
                state_next = ST_ML;
            end
            ST_ML:
            begin
                dacc_next  = QW'(p_reg);
                state_next = ST_MD;
            end
            ST_MD:
            begin
                d_next     = (dsum < QW'(DEN_MIN)) ? QW'(DEN_MIN) : dsum;
                state_next = ST_CGO;
            end
            ST_CGO:
            begin
                state_next = ST_CW;
            end
            ST_CW:
            begin
                if (iter_done)
                begin
                    if (q_corr[CORR_FRAC])
                        corr_next = cross_reg[PWR-1] ? {1'b1, {CORR_FRAC{1'b0}}}
                                                     : {1'b0, {CORR_FRAC{1'b1}}};
                    else if (cross_reg[PWR-1])
                        corr_next = -$signed({1'b0, q_corr[CORR_FRAC-1:0]});
                    else
                        corr_next = $signed({1'b0, q_corr[CORR_FRAC-1:0]});
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next.out_left    = out_l_reg;
                    res_next.out_right   = out_r_reg;
                    res_next.correlation = corr_reg;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg        <= TARGET_WIDTH_RESET;
            tc_reg        <= TARGET_CUTOFF_RESET;
            mono_low_reg  <= 1'b0;
            fs_reg        <= SAMPLE_RATE_RESET;
            coef_reg      <= SMOOTH_RESET;
            mono_src_reg  <= 1'b0;
            state_reg     <= ST_IDLE;
            x_l_reg       <= '0;
            x_r_reg       <= '0;
            be_reg        <= 1'b0;
            ww_reg        <= {1'b0, TARGET_WIDTH_RESET, 16'h0};
            wc_reg        <= {1'b0, TARGET_CUTOFF_RESET, 16'h0};
            a_reg         <= '0;
            alpha_reg     <= '0;
            low_l_reg     <= '0;
            low_r_reg     <= '0;
            out_l_reg     <= '0;
            out_r_reg     <= '0;
            cross_reg     <= '0;
            lpow_reg      <= '0;
            rpow_reg      <= '0;
            sl_reg        <= '0;
            sr_reg        <= '0;
            dacc_reg      <= '0;
            d_reg         <= '0;
            corr_reg      <= '0;
            p_reg         <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TARGET_WIDTH:  tw_reg       <= cfg_data[WIDTH_BITS-1:0];
                    REG_TARGET_CUTOFF: tc_reg       <= cfg_data[CUTOFF_BITS-1:0];
                    REG_MONO_LOW:      mono_low_reg <= cfg_data[0];
                    REG_SAMPLE_RATE:   fs_reg       <= cfg_data[RATE_BITS-1:0];
                    REG_SMOOTH:        coef_reg     <= cfg_data[SMOOTH_BITS-1:0];
                    REG_MONO_SOURCE:   mono_src_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            state_reg     <= state_next;
            x_l_reg       <= x_l_next;
            x_r_reg       <= x_r_next;
            be_reg        <= be_next;
            ww_reg        <= ww_next;
            wc_reg        <= wc_next;
            a_reg         <= a_next;
            alpha_reg     <= alpha_next;
            low_l_reg     <= low_l_next;
            low_r_reg     <= low_r_next;
            out_l_reg     <= out_l_next;
            out_r_reg     <= out_r_next;
            cross_reg     <= cross_next;
            lpow_reg      <= lpow_next;
            rpow_reg      <= rpow_next;
            sl_reg        <= sl_next;
            sr_reg        <= sr_next;
            dacc_reg      <= dacc_next;
            d_reg         <= d_next;
            corr_reg      <= corr_next;
            p_reg         <= p_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

endmodule

FILE: rtl/swmb_checker.sv
// Port-level checks for the stereo widener, attached to the top level by bind.
// Depends on swmb_pkg and the assertion macros header.
`include "stereo_widener_mono_bass_macros.svh"

module swmb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input swmb_pkg::result_t result
);

    // An accepted item keeps the block busy for at least the next cycle.
    `SWMB_ASSERT(a_busy_after_accept, (sample_valid && !sample_stall) |=> sample_stall, "item accepted but block not busy")

    // A new result only appears right after the block was busy with an item.
    `SWMB_ASSERT(a_result_after_work, $rose(result_valid) |-> $past(sample_stall), "result without work")

    `SWMB_ASSERT(a_result_holds, (result_valid && result_stall) |=> (result_valid && $stable(result)), "stalled result changed")

    `SWMB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!result_valid && !sample_stall), "outputs active in reset")

endmodule

bind stereo_widener_mono_bass swmb_checker u_swmb_checker (.*);

FILE: bench/stereo_widener_mono_bass_tb.sv
// Self-checking testbench for the stereo widener with mono bass.
// Depends on swmb_pkg and stereo_widener_mono_bass; a built-in bit-exact model
// predicts every output item, and a monitor compares each one in order.
module stereo_widener_mono_bass_tb;
    import swmb_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HI = 3'd7;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     HOLD_CYCLES = 3000;
    localparam int     SETTLE_CYCLES = 200;

    logic                      clk;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_stall;
    sample_t                   sample;
    logic                      result_valid;
    logic                      result_stall;
    result_t                   result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    stereo_widener_mono_bass u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Model copy of the registers and the filter state.
    logic [14:0] tgt_width;
    logic [14:0] tgt_cutoff;
    logic        mono_low;
    logic [17:0] rate_hz;
    logic [15:0] smooth;
    logic        mono_src;
    longint      cur_width;
    longint      cur_cutoff;
    longint      lp_left;
    longint      lp_right;
    longint      pow_cross;
    longint      pow_left;
    longint      pow_right;
    longint      corr_hold;

    result_t expected_outputs[$];
    int      errors = 0;
    longint  cycles;
    int      burst_left;
    bit      hold_req;

    function automatic longint floor_scale(longint x, longint a, int s);
        longint h;
        longint l;
        h = x >>> s;
        l = x - (h <<< s);
        return h * a + ((l * a) >>> s);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    // Advances the model by one sample and returns the output item it produces.
    function automatic result_t widen_sample(sample_t s);
        longint          in_l, in_r, a, den, alpha, xl, xr, lo_l, lo_r;
        longint          hl, hr, mid, side, ol, orr, d, c;
        longint unsigned pl, pr, sl, sr;
        result_t         r;
        in_l = s.in_left;
        in_r = mono_src ? in_l : longint'(s.in_right);
        cur_width  += floor_scale((longint'(tgt_width) <<< 16) - cur_width, smooth, 16);
        cur_cutoff += floor_scale((longint'(tgt_cutoff) <<< 16) - cur_cutoff, smooth, 16);
        a = (longint'(TWO_PI_Q16) * cur_cutoff) >>> 16;
        den = a + (longint'(rate_hz) <<< 16);
        alpha = (den <= 0) ? 1 : (a <<< 16) / den;
        if (alpha < 1)
            alpha = 1;
        if (alpha > 65535)
            alpha = 65535;
        xl = in_l * 256;
        xr = in_r * 256;
        lp_left  += floor_scale(xl - lp_left, alpha, 16);
        lp_right += floor_scale(xr - lp_right, alpha, 16);
        lo_l = lp_left;
        lo_r = lp_right;
        if (mono_low)
        begin
            lo_l = (lp_left + lp_right) >>> 1;
            lo_r = lo_l;
        end
        hl = xl - lp_left;
        hr = xr - lp_right;
        mid = (hl + hr) >>> 1;
        side = ((hl - hr) * (cur_width >>> 16)) >>> 13;
        ol  = clip24((lo_l + mid + side + 128) >>> 8);
        orr = clip24((lo_r + mid - side + 128) >>> 8);
        pow_cross += floor_scale(ol * orr - pow_cross, 66, 16);
        pow_left  += floor_scale(ol * ol - pow_left, 66, 16);
        pow_right += floor_scale(orr * orr - pow_right, 66, 16);
        if (s.block_end)
        begin
            pl = pow_left > 0 ? pow_left : 0;
            pr = pow_right > 0 ? pow_right : 0;
            sl = int_sqrt(pl << 16);
            sr = int_sqrt(pr << 16);
            d = (sl * sr) >> 16;
            if (d < longint'(DEN_MIN))
                d = longint'(DEN_MIN);
            c = (pow_cross * 32768) / d;
            if (c > 32767)
                c = 32767;
            if (c < -32768)
                c = -32768;
            corr_hold = c;
        end
        r.out_left    = ol[23:0];
        r.out_right   = orr[23:0];
        r.correlation = corr_hold[15:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("stereo_widener_mono_bass_tb: FAIL");
                $finish;
            end
        end
    end

    // Receiver stall: a changing pattern, plus one long hold-off on request.
    initial
    begin
        int mode;
        int left_in_mode;
        bit held;
        mode = 0;
        left_in_mode = 0;
        held = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            if (left_in_mode == 0)
            begin
                mode = $urandom_range(0, 2);
                left_in_mode = $urandom_range(50, 600);
            end
            left_in_mode--;
            case (mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 9) < 3);
                default: result_stall <= (cycles % 4 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                $display("%0t: unexpected output item %h", $time, result);
                errors++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (result.out_left !== want.out_left)
                begin
                    $display("%0t: out_left expected %0d actual %0d",
                             $time, want.out_left, result.out_left);
                    errors++;
                end
                if (result.out_right !== want.out_right)
                begin
                    $display("%0t: out_right expected %0d actual %0d",
                             $time, want.out_right, result.out_right);
                    errors++;
                end
                if (result.correlation !== want.correlation)
                begin
                    $display("%0t: correlation expected %0d actual %0d",
                             $time, want.correlation, result.correlation);
                    errors++;
                end
            end
        end
    end

    task automatic send_sample(sample_t s);
        int gap;
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        expected_outputs.push_back(widen_sample(s));
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(1, 30);
        end
        burst_left--;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET_WIDTH:  tgt_width  = value[14:0];
            REG_TARGET_CUTOFF: tgt_cutoff = value[14:0];
            REG_MONO_LOW:      mono_low   = value[0];
            REG_SAMPLE_RATE:   rate_hz    = value[17:0];
            REG_SMOOTH:        smooth     = value[15:0];
            REG_MONO_SOURCE:   mono_src   = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic sample_t make_sample(int kind, bit last);
        sample_t s;
        case (kind)
            0:
            begin
                s.in_left  = 24'($urandom);
                s.in_right = 24'($urandom);
            end
            1:
            begin
                s.in_left  = 24'($urandom_range(0, 4000) - 2000);
                s.in_right = 24'($urandom_range(0, 4000) - 2000);
            end
            2:
            begin
                s.in_left  = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                s.in_right = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            end
            default:
            begin
                s.in_left  = 24'($urandom);
                s.in_right = s.in_left ^ 24'($urandom_range(0, 255));
            end
        endcase
        s.block_end = last;
        return s;
    endfunction

    task automatic send_pair(int l, int r, bit last);
        sample_t s;
        s.in_left   = 24'(l);
        s.in_right  = 24'(r);
        s.block_end = last;
        send_sample(s);
    endtask

    task automatic test_extremes;
        send_pair(8388607, -8388608, 1'b0);
        send_pair(-8388608, 8388607, 1'b0);
        send_pair(8388607, 8388607, 1'b1);
        send_pair(-8388608, -8388608, 1'b0);
        send_pair(0, 0, 1'b1);
        send_pair(-1, 1, 1'b1);
        drain();
    endtask

    task automatic test_mono_paths;
        write_reg(REG_MONO_SOURCE, 1);
        write_reg(REG_MONO_LOW, 1);
        write_reg(REG_TARGET_CUTOFF, 20000);
        send_pair(8388607, -8388608, 1'b0);
        send_pair(-3000000, 5, 1'b1);
        send_pair(1234567, -7654321, 1'b1);
        drain();
        write_reg(REG_MONO_SOURCE, 0);
        send_pair(8388607, -8388608, 1'b0);
        send_pair(-8388608, 8388607, 1'b1);
        drain();
    endtask

    // Zero rate with cutoff driven to zero, then zero rate with a live cutoff.
    task automatic test_zero_rate;
        write_reg(REG_SAMPLE_RATE, 0);
        write_reg(REG_SMOOTH, 65535);
        write_reg(REG_TARGET_CUTOFF, 0);
        repeat (4) send_pair(4000000, -4000000, 1'b0);
        send_pair(-4000000, 4000000, 1'b1);
        drain();
        write_reg(REG_TARGET_CUTOFF, 32767);
        send_pair(8388607, 0, 1'b1);
        send_pair(0, 8388607, 1'b0);
        drain();
    endtask

    task automatic test_frozen_wide;
        write_reg(REG_SAMPLE_RATE, 192000);
        write_reg(REG_TARGET_WIDTH, 32767);
        write_reg(REG_SMOOTH, 65535);
        send_pair(8388607, -8388608, 1'b0);
        drain();
        write_reg(REG_SMOOTH, 0);
        write_reg(REG_TARGET_WIDTH, 0);
        send_pair(-8388608, 8388607, 1'b1);
        send_pair(3000000, -3000000, 1'b0);
        drain();
    endtask

    task automatic test_unused_index;
        write_reg(REG_UNUSED_LO, 18'h3FFFF);
        write_reg(REG_UNUSED_HI, 0);
        send_pair(100000, -100000, 1'b1);
        drain();
    endtask

    task automatic test_backpressure;
        hold_req = 1'b1;
        repeat (40) send_sample(make_sample($urandom_range(0, 3), $urandom_range(0, 7) == 0));
        drain();
    endtask

    task automatic test_random_phases;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_TARGET_WIDTH, phase == 0 ? 0 : (phase == 1 ? 16384 :
                      $urandom_range(0, 16384)));
            write_reg(REG_TARGET_CUTOFF, phase == 1 ? 20000 : $urandom_range(0, 20000));
            write_reg(REG_MONO_LOW, $urandom_range(0, 1));
            write_reg(REG_SAMPLE_RATE, phase == 0 ? 8000 : (phase == 1 ? 192000 :
                      $urandom_range(8000, 192000)));
            write_reg(REG_SMOOTH, phase == 2 ? 1 : $urandom_range(1, 65535));
            write_reg(REG_MONO_SOURCE, phase == 3);
            repeat (200)
                send_sample(make_sample($urandom_range(0, 3), $urandom_range(0, 15) == 0));
            drain();
        end
    endtask

    initial
    begin
        burst_left   = 0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tgt_width    = TARGET_WIDTH_RESET;
        tgt_cutoff   = TARGET_CUTOFF_RESET;
        mono_low     = 1'b0;
        rate_hz      = SAMPLE_RATE_RESET;
        smooth       = SMOOTH_RESET;
        mono_src     = 1'b0;
        cur_width    = longint'(TARGET_WIDTH_RESET) <<< 16;
        cur_cutoff   = longint'(TARGET_CUTOFF_RESET) <<< 16;
        lp_left      = 0;
        lp_right     = 0;
        pow_cross    = 0;
        pow_left     = 0;
        pow_right    = 0;
        corr_hold    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        test_extremes();
        test_mono_paths();
        test_zero_rate();
        test_frozen_wide();
        test_unused_index();
        test_backpressure();
        test_random_phases();
        if (errors == 0)
            $display("stereo_widener_mono_bass_tb: PASS");
        else
            $display("stereo_widener_mono_bass_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/swmb_pkg.sv
rtl/swmb_iter.sv
rtl/stereo_widener_mono_bass.sv
rtl/swmb_checker.sv
bench/stereo_widener_mono_bass_tb.sv
